FILE: hw/rtl/stl_pkg.sv
package stl_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [2:0] KIND_SEMI  = 3'd0;
  localparam logic [2:0] KIND_VAR   = 3'd1;
  localparam logic [2:0] KIND_SYM   = 3'd2;
  localparam logic [2:0] KIND_STR   = 3'd3;
  localparam logic [2:0] KIND_CLOSE = 3'd4;
  localparam logic [2:0] KIND_CURLY = 3'd5;
  localparam logic [2:0] KIND_EOL   = 3'd6;
  localparam logic [2:0] KIND_ERR   = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LCURLY = 8'h7b;
  localparam logic [7:0] CH_RCURLY = 8'h7d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  // one result as it leaves the block
  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       te;
    logic [2:0] kind;
    logic       done;
  } res_t;

  // one queued request: one or two results
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic logic is_sym_char(logic [7:0] c);
    logic s;
    s = 1'b0;
    if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)) s = 1'b1;
    if ((c >= 8'h30 && c <= 8'h39) || c == 8'h2e) s = 1'b1;
    if (c == 8'h21 || (c >= 8'h25 && c <= 8'h2f) || (c >= 8'h3a && c <= 8'h40)) s = 1'b1;
    if (c == 8'h60 || c == 8'h7c || c == 8'h5e || c == 8'h5f || c == CH_TILDE ||
        c == CH_BSLASH) s = 1'b1;
    return s;
  endfunction

  function automatic res_t make_res(logic [7:0] ch, logic cv, logic te, logic [2:0] kind);
    res_t r;
    r.ch   = cv ? ch : 8'h00;
    r.cv   = cv;
    r.te   = te;
    r.kind = te ? kind : 3'd0;
    r.done = 1'b0;
    return r;
  endfunction

endpackage

FILE: hw/rtl/script_token_lexer_core.sv
// channel  | dir | tdata                                   | tuser          | tlast
// s_axis   | in  | [7:0] in_char                           | -              | -
// m_axis   | out | [7:0] out_char, [8] char_valid,         | [2:0]          | item_done
//          |     | [9] token_end, [15:10] zero             | token_kind     |
//
// one input character accepted per cycle while the request queue has room
// a character giving two results has them sent one after the other; the back end
// delivers one result per cycle from its output register while results wait and m_tready is high
// zero-result characters (whitespace, openers, '$' between tokens) never enter the queue
// synchronous reset puts the lexer between tokens and empties queue and output
// input and output stall independently through the queue of QUEUE_DEPTH entries
module script_token_lexer_core #(
  parameter int unsigned QUEUE_DEPTH = stl_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_char, [8] char_valid, [9] token_end
  output logic [2:0]  m_tuser,   // [2:0] token_kind
  output logic        m_tlast    // item_done
);

  logic            push, pop, full, empty;
  stl_pkg::entry_t wr_entry, head;
  stl_pkg::res_t   res;

  assign s_tready = !full;

  stl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (s_tvalid && s_tready),
    .in_char (s_tdata),
    .push    (push),
    .entry   (wr_entry)
  );

  stl_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .full    (full),
    .pop     (pop),
    .rd_data (head),
    .empty   (empty)
  );

  stl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (res)
  );

  assign m_tdata = {6'b0, res.te, res.cv, res.ch};
  assign m_tuser = res.kind;
  assign m_tlast = res.done;

endmodule

FILE: hw/rtl/stl_front.sv
module stl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_char,
  output logic              push,
  output stl_pkg::entry_t   entry
);

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_SYM     = 6'b000010,
    MODE_VAR     = 6'b000100,
    MODE_BRACKET = 6'b001000,
    MODE_CURLY   = 6'b010000,
    MODE_QUOTE   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic          has;
    stl_pkg::res_t res;
    mode_t         mode;
  } start_t;

  mode_t mode, mode_next;
  logic  has_any;

  function automatic start_t start_token(logic [7:0] c);
    start_t s;
    s.has  = 1'b0;
    s.res  = stl_pkg::make_res(c, 1'b0, 1'b0, stl_pkg::KIND_SEMI);
    s.mode = MODE_IDLE;
    if (c == stl_pkg::CH_SPACE || c == stl_pkg::CH_TAB || c == stl_pkg::CH_NL) begin
      s.has = 1'b0;
    end else if (c == stl_pkg::CH_SEMI) begin
      s.has = 1'b1;
      s.res = stl_pkg::make_res(c, 1'b1, 1'b1, stl_pkg::KIND_SEMI);
    end else if (c == stl_pkg::CH_DOLLAR) begin
      s.mode = MODE_VAR;
    end else if (stl_pkg::is_sym_char(c)) begin
      s.has  = 1'b1;
      s.res  = stl_pkg::make_res(c, 1'b1, 1'b0, stl_pkg::KIND_SEMI);
      s.mode = MODE_SYM;
    end else if (c == stl_pkg::CH_LBRACK) begin
      s.mode = MODE_BRACKET;
    end else if (c == stl_pkg::CH_RBRACK) begin
      s.has = 1'b1;
      s.res = stl_pkg::make_res(c, 1'b1, 1'b1, stl_pkg::KIND_CLOSE);
    end else if (c == stl_pkg::CH_LCURLY) begin
      s.mode = MODE_CURLY;
    end else if (c == stl_pkg::CH_QUOTE) begin
      s.mode = MODE_QUOTE;
    end else if (c == stl_pkg::CH_NUL) begin
      s.has = 1'b1;
      s.res = stl_pkg::make_res(c, 1'b0, 1'b1, stl_pkg::KIND_EOL);
    end else begin
      s.has = 1'b1;
      s.res = stl_pkg::make_res(c, 1'b1, 1'b1, stl_pkg::KIND_ERR);
    end
    return s;
  endfunction

  always_comb begin
    start_t     st;
    logic [7:0] close_ch;
    logic [2:0] body_kind;
    st        = start_token(in_char);
    close_ch  = stl_pkg::CH_QUOTE;
    body_kind = stl_pkg::KIND_STR;
    entry.two = 1'b0;
    entry.r0  = st.res;
    entry.r1  = st.res;
    has_any   = st.has;
    mode_next = st.mode;
    unique case (mode)
      MODE_SYM, MODE_VAR: begin
        if (stl_pkg::is_sym_char(in_char)) begin
          entry.r0  = stl_pkg::make_res(in_char, 1'b1, 1'b0, stl_pkg::KIND_SEMI);
          has_any   = 1'b1;
          mode_next = mode;
        end else begin
          // token closes, then the ending character starts the next one
          entry.r0  = stl_pkg::make_res(in_char, 1'b0, 1'b1,
                        (mode == MODE_SYM) ? stl_pkg::KIND_SYM : stl_pkg::KIND_VAR);
          entry.two = st.has;
          has_any   = 1'b1;
        end
      end
      MODE_BRACKET, MODE_CURLY, MODE_QUOTE: begin
        if (mode == MODE_BRACKET) close_ch = stl_pkg::CH_RBRACK;
        else if (mode == MODE_CURLY) close_ch = stl_pkg::CH_RCURLY;
        if (mode == MODE_CURLY) body_kind = stl_pkg::KIND_CURLY;
        has_any = 1'b1;
        if (in_char == stl_pkg::CH_NUL) begin
          entry.r0  = stl_pkg::make_res(in_char, 1'b0, 1'b1, stl_pkg::KIND_ERR);
          entry.r1  = stl_pkg::make_res(in_char, 1'b0, 1'b1, stl_pkg::KIND_EOL);
          entry.two = 1'b1;
          mode_next = MODE_IDLE;
        end else if (in_char == close_ch) begin
          entry.r0  = stl_pkg::make_res(in_char, 1'b0, 1'b1, body_kind);
          mode_next = MODE_IDLE;
        end else begin
          entry.r0  = stl_pkg::make_res(in_char, 1'b1, 1'b0, stl_pkg::KIND_SEMI);
          mode_next = mode;
        end
      end
      default: begin
      end
    endcase
    entry.r0.done = !entry.two;
    entry.r1.done = 1'b1;
  end

  assign push = accept && has_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

FILE: hw/rtl/stl_fifo.sv
module stl_fifo #(
  parameter int unsigned DEPTH = stl_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stl_pkg::entry_t wr_data,
  output logic            full,
  input  logic            pop,
  output stl_pkg::entry_t rd_data,
  output logic            empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  stl_pkg::entry_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");

endmodule

FILE: hw/rtl/stl_back.sv
module stl_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  stl_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output stl_pkg::res_t   out_res
);

  logic          phase, phase_next;
  logic          out_valid_next;
  stl_pkg::res_t out_res_next;

  always_comb begin
    pop            = 1'b0;
    phase_next     = phase;
    out_valid_next = out_valid && !out_ready;
    out_res_next   = out_res;
    // output register is free or drains this cycle
    if ((!out_valid || out_ready) && head_valid) begin
      out_valid_next = 1'b1;
      if (phase) begin
        out_res_next = head.r1;
        pop          = 1'b1;
        phase_next   = 1'b0;
      end else begin
        out_res_next = head.r0;
        if (head.two) phase_next = 1'b1;
        else pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res <= out_res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      phase     <= phase_next;
    end
  end

  a_second_half: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head_valid && head.two))
    else $error("second result pending without a two-result request");

endmodule
